FILE: sv/modbus_rtu_request_deframer_top_macros.svh
// ----------------------------------------------------------------------------
// Modbus RTU request deframer assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_REQUEST_DEFRAMER_TOP_MACROS_SVH
`define MODBUS_RTU_REQUEST_DEFRAMER_TOP_MACROS_SVH

// same-cycle implication, quiet during reset
`define MRD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define MRD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/mrd_pkg.sv
// ----------------------------------------------------------------------------
// Modbus RTU request deframer package
// Types, codes and constants shared by the deframer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mrd_pkg;

    localparam int DEPTH_DEF    = 256;
    localparam int LEN_W        = 10;
    localparam int MIN_SCAN     = 7;
    localparam int RESULT_LIMIT = 32;
    localparam int CNT_W        = 6;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 17;

    localparam logic [7:0] FC_READ  = 8'h03;
    localparam logic [7:0] FC_WRITE = 8'h10;
    localparam logic [7:0] FC_MCH   = 8'h13;

    localparam logic [1:0] ACT_LOCAL_READ  = 2'd0;
    localparam logic [1:0] ACT_LOCAL_WRITE = 2'd1;
    localparam logic [1:0] ACT_LOCAL_MCH   = 2'd2;
    localparam logic [1:0] ACT_FORWARD     = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HIGH  = 2'd2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FC,
        ST_B2,
        ST_B6,
        ST_CHK,
        ST_WALK,
        ST_EVAL,
        ST_FINISH
    } mrd_state_t;

    typedef struct packed {
        logic load;
        logic rd_fc;
        logic rd_b2;
        logic rd_b6;
        logic cap_fc;
        logic cap_b2;
        logic cap_b6;
        logic walk_init;
        logic walk_run;
        logic drop;
        logic take;
        logic push;
    } mrd_cmd_t;

    typedef struct packed {
        logic fill_ge_min;
        logic fc_known;
        logic len_big;
        logic len_short;
        logic walk_done;
        logic crc_ok;
        logic pend_vld;
        logic out_busy;
    } mrd_stat_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  device_addr;
        logic [7:0]  function_code;
        logic [15:0] start_addr;
        logic [15:0] reg_count;
        logic [15:0] first_channel;
        logic [7:0]  chan_total;
        logic [8:0]  frame_length;
        logic [7:0]  dropped_bytes;
    } mrd_res_t;

endpackage

FILE: sv/mrd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/mrd_ctrl.sv
// ----------------------------------------------------------------------------
// Deframer controller
// Sequences buffer loads, header reads, the CRC walk and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mrd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mrd_pkg::mrd_stat_t stat,
    output mrd_pkg::mrd_cmd_t  cmd
);

    import mrd_pkg::*;

    mrd_state_t       state_reg;
    mrd_state_t       state_next;
    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] n_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    n_next     = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!stat.fill_ge_min)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.rd_fc  = 1'b1;
                    state_next = ST_FC;
                end
            end
            ST_FC:
            begin
                cmd.cap_fc = 1'b1;
                cmd.rd_b2  = 1'b1;
                state_next = ST_B2;
            end
            ST_B2:
            begin
                cmd.cap_b2 = 1'b1;
                cmd.rd_b6  = 1'b1;
                state_next = ST_B6;
            end
            ST_B6:
            begin
                cmd.cap_b6 = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                priority if (!stat.fc_known || stat.len_big)
                begin
                    cmd.drop   = 1'b1;
                    state_next = ST_SCAN;
                end
                else if (stat.len_short)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.walk_init = 1'b1;
                    state_next    = ST_WALK;
                end
            end
            ST_WALK:
            begin
                cmd.walk_run = 1'b1;
                if (stat.walk_done)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                priority if (!stat.crc_ok)
                begin
                    cmd.drop   = 1'b1;
                    state_next = ST_SCAN;
                end
                else if (stat.pend_vld && stat.out_busy)
                begin
                    state_next = ST_EVAL;
                end
                else
                begin
                    cmd.take = 1'b1;
                    n_next   = n_reg + CNT_W'(1);
                    if (n_next == CNT_W'(RESULT_LIMIT))
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_FINISH:
            begin
                priority if (!stat.pend_vld)
                begin
                    state_next = ST_IDLE;
                end
                else if (!stat.out_busy)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/mrd_datapath.sv
// ----------------------------------------------------------------------------
// Deframer datapath
// Frame buffer pointers, header decode, CRC-16 walk and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mrd_datapath #(
    parameter int BUFFER_DEPTH = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mrd_pkg::mrd_cmd_t               cmd,
    output mrd_pkg::mrd_stat_t              stat,
    input  logic [7:0]                      rx_byte,
    input  logic                            cfg_write,
    input  logic [mrd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mrd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            out_ready,
    output logic                            out_valid,
    output mrd_pkg::mrd_res_t               out_res,
    output logic                            out_last
);

    import mrd_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int FW = AW + 1;
    localparam int CW = (FW > LEN_W) ? FW : LEN_W;
    localparam logic [CW:0]   DEPTH_W = (CW+1)'(BUFFER_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);
    localparam logic [FW-1:0] DEPTH_F = FW'(BUFFER_DEPTH);

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(off);
        if (sum >= DEPTH_W)
        begin
            sum = sum - DEPTH_W;
        end
        return sum[AW-1:0];
    endfunction

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    logic [AW-1:0]   head_reg;
    logic [FW-1:0]   fill_reg;
    logic [7:0]      drop_reg;
    logic            fwd_reg;
    logic [15:0]     wlo_reg;
    logic [16:0]     whi_reg;

    logic [7:0]      fc_reg;
    logic [7:0]      b2_reg;
    logic [7:0]      b6_reg;
    logic [7:0]      dev_reg;
    logic [7:0]      b3_reg;
    logic [7:0]      b4_reg;
    logic [7:0]      b5_reg;
    logic [7:0]      chh_reg;
    logic [7:0]      chl_reg;
    logic [7:0]      chc_reg;
    logic [7:0]      crcl_reg;
    logic [7:0]      crch_reg;
    logic [15:0]     crc_reg;
    logic [CW-1:0]   rd_off_reg;
    logic [CW-1:0]   dly_off_reg;
    logic            dly_vld_reg;

    mrd_res_t        pend_reg;
    logic            pend_vld_reg;
    mrd_res_t        out_reg;
    logic            out_last_reg;
    logic            out_vld_reg;

    logic [LEN_W-1:0] len;
    logic [CW-1:0]    lenc;
    logic             fc_known;
    logic [AW-1:0]    raddr;
    logic [AW-1:0]    waddr;
    logic [CW-1:0]    roff;
    logic [7:0]       q;
    logic             walk_issue;
    mrd_res_t         res_new;
    logic [15:0]      start_v;
    logic [15:0]      count_v;
    logic [15:0]      span_v;
    logic             local_v;
    logic [7:0]       drop_sat;

    always_comb
    begin
        fc_known = 1'b1;
        unique case (fc_reg)
            FC_READ:  len = LEN_W'(8);
            FC_WRITE: len = LEN_W'(b6_reg) + LEN_W'(9);
            FC_MCH:   len = LEN_W'(8) + LEN_W'({b2_reg, 1'b0});
            default:
            begin
                len      = LEN_W'(8);
                fc_known = 1'b0;
            end
        endcase
    end

    assign lenc = CW'(len);

    assign walk_issue = cmd.walk_run && (rd_off_reg < lenc);

    always_comb
    begin
        priority if (cmd.rd_fc)
        begin
            roff = CW'(1);
        end
        else if (cmd.rd_b2)
        begin
            roff = CW'(2);
        end
        else if (cmd.rd_b6)
        begin
            roff = CW'(6);
        end
        else
        begin
            roff = rd_off_reg;
        end
    end

    assign raddr = wrap_add(head_reg, roff);
    assign waddr = wrap_add(head_reg, CW'(fill_reg));

    mrd_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.load),
        .waddr (waddr),
        .wdata (rx_byte),
        .raddr (raddr),
        .rdata (q)
    );

    assign stat.fill_ge_min = CW'(fill_reg) >= CW'(MIN_SCAN);
    assign stat.fc_known    = fc_known;
    assign stat.len_big     = lenc > DEPTH_C;
    assign stat.len_short   = CW'(fill_reg) < lenc;
    assign stat.walk_done   = dly_vld_reg && (dly_off_reg == lenc - CW'(1));
    assign stat.crc_ok      = crc_reg == {crch_reg, crcl_reg};
    assign stat.pend_vld    = pend_vld_reg;
    assign stat.out_busy    = out_vld_reg && !out_ready;

    assign drop_sat = (drop_reg == 8'hFF) ? drop_reg : drop_reg + 8'd1;

    always_comb
    begin
        start_v = {b2_reg, b3_reg};
        count_v = {b4_reg, b5_reg};
        span_v  = (fc_reg == FC_READ) ? count_v : {9'd0, b6_reg[7:1]};
        local_v = (start_v >= wlo_reg) && ((17'(start_v) + 17'(span_v)) < whi_reg);
        res_new.device_addr   = dev_reg;
        res_new.function_code = fc_reg;
        res_new.frame_length  = len[8:0];
        res_new.dropped_bytes = drop_reg;
        if (fc_reg == FC_MCH)
        begin
            res_new.action        = ACT_LOCAL_MCH;
            res_new.start_addr    = '0;
            res_new.reg_count     = {8'd0, b2_reg};
            res_new.first_channel = {chh_reg, chl_reg};
            res_new.chan_total    = chc_reg;
        end
        else
        begin
            if (fwd_reg && !local_v)
            begin
                res_new.action = ACT_FORWARD;
            end
            else if (fc_reg == FC_READ)
            begin
                res_new.action = ACT_LOCAL_READ;
            end
            else
            begin
                res_new.action = ACT_LOCAL_WRITE;
            end
            res_new.start_addr    = start_v;
            res_new.reg_count     = count_v;
            res_new.first_channel = '0;
            res_new.chan_total    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            fill_reg     <= '0;
            drop_reg     <= '0;
            fwd_reg      <= 1'b0;
            wlo_reg      <= '0;
            whi_reg      <= '0;
            dly_vld_reg  <= 1'b0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_FORWARD_MODE: fwd_reg <= cfg_data[0];
                    CFG_WINDOW_LOW:   wlo_reg <= cfg_data[15:0];
                    CFG_WINDOW_HIGH:  whi_reg <= cfg_data[16:0];
                    default:          ;
                endcase
            end

            priority if (cmd.load)
            begin
                if (fill_reg == DEPTH_F)
                begin
                    head_reg <= wrap_add(head_reg, CW'(1));
                    drop_reg <= drop_sat;
                end
                else
                begin
                    fill_reg <= fill_reg + FW'(1);
                end
            end
            else if (cmd.drop)
            begin
                head_reg <= wrap_add(head_reg, CW'(1));
                fill_reg <= fill_reg - FW'(1);
                drop_reg <= drop_sat;
            end
            else if (cmd.take)
            begin
                head_reg <= wrap_add(head_reg, lenc);
                fill_reg <= fill_reg - FW'(lenc);
                drop_reg <= '0;
            end

            if (cmd.walk_init)
            begin
                dly_vld_reg <= 1'b0;
            end
            else
            begin
                dly_vld_reg <= walk_issue;
            end

            priority if (cmd.take)
            begin
                pend_vld_reg <= 1'b1;
                if (pend_vld_reg)
                begin
                    out_vld_reg <= 1'b1;
                end
                else if (out_ready)
                begin
                    out_vld_reg <= 1'b0;
                end
            end
            else if (cmd.push)
            begin
                pend_vld_reg <= 1'b0;
                out_vld_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_fc)
        begin
            fc_reg <= q;
        end
        if (cmd.cap_b2)
        begin
            b2_reg <= q;
        end
        if (cmd.cap_b6)
        begin
            b6_reg <= q;
        end

        if (cmd.walk_init)
        begin
            rd_off_reg <= '0;
            crc_reg    <= CRC_INIT;
        end
        else if (walk_issue)
        begin
            rd_off_reg  <= rd_off_reg + CW'(1);
            dly_off_reg <= rd_off_reg;
        end

        if (dly_vld_reg)
        begin
            if (dly_off_reg == CW'(0))
            begin
                dev_reg <= q;
            end
            if (dly_off_reg == CW'(3))
            begin
                b3_reg <= q;
            end
            if (dly_off_reg == CW'(4))
            begin
                b4_reg <= q;
            end
            if (dly_off_reg == CW'(5))
            begin
                b5_reg <= q;
            end
            if (dly_off_reg == lenc - CW'(5))
            begin
                chh_reg <= q;
            end
            if (dly_off_reg == lenc - CW'(4))
            begin
                chl_reg <= q;
            end
            if (dly_off_reg == lenc - CW'(3))
            begin
                chc_reg <= q;
            end
            if (dly_off_reg == lenc - CW'(2))
            begin
                crcl_reg <= q;
            end
            if (dly_off_reg == lenc - CW'(1))
            begin
                crch_reg <= q;
            end
            if (dly_off_reg < lenc - CW'(2))
            begin
                crc_reg <= crc_byte(crc_reg, q);
            end
        end

        if (cmd.take)
        begin
            pend_reg <= res_new;
            if (pend_vld_reg)
            begin
                out_reg      <= pend_reg;
                out_last_reg <= 1'b0;
            end
        end
        else if (cmd.push)
        begin
            out_reg      <= pend_reg;
            out_last_reg <= 1'b1;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_res   = out_reg;
    assign out_last  = out_last_reg;

endmodule

FILE: sv/modbus_rtu_request_deframer_top.sv
// After a beat, in_ready stays low until the controller is back in IDLE: through SCAN
// and FINISH while fewer than 7 bytes are held, else through SCAN, FC, B2, B6 and CHK
// per decode pass, WALK and EVAL for a complete frame, and a final SCAN when fewer than 7 bytes remain.
// The block takes no new byte until it is done with the last one; a full output register
// and result slot hold the input.
// Reset: pointers, counts, config registers and valid flags clear; buffer contents, header and result registers do not.
// ----------------------------------------------------------------------------
// Modbus RTU request deframer
// Buffers received bytes, finds request frames by CRC-16 and reports them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module modbus_rtu_request_deframer_top #(
    parameter int BUFFER_DEPTH = mrd_pkg::DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [mrd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mrd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     rx_byte,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     action,
    output logic [7:0]                     device_addr,
    output logic [7:0]                     function_code,
    output logic [15:0]                    start_addr,
    output logic [15:0]                    reg_count,
    output logic [15:0]                    first_channel,
    output logic [7:0]                     chan_total,
    output logic [8:0]                     frame_length,
    output logic [7:0]                     dropped_bytes,
    output logic                           last_result
);

    import mrd_pkg::*;

    mrd_cmd_t  cmd;
    mrd_stat_t stat;
    mrd_res_t  res;

    mrd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mrd_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .rx_byte   (rx_byte),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_res   (res),
        .out_last  (last_result)
    );

    assign action        = res.action;
    assign device_addr   = res.device_addr;
    assign function_code = res.function_code;
    assign start_addr    = res.start_addr;
    assign reg_count     = res.reg_count;
    assign first_channel = res.first_channel;
    assign chan_total    = res.chan_total;
    assign frame_length  = res.frame_length;
    assign dropped_bytes = res.dropped_bytes;

endmodule

FILE: sv/mrd_checker.sv
// ----------------------------------------------------------------------------
// Deframer port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "modbus_rtu_request_deframer_top_macros.svh"

module mrd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  action,
    input logic [7:0]  function_code,
    input logic [15:0] first_channel,
    input logic [7:0]  chan_total,
    input logic [8:0]  frame_length,
    input logic        last_result
);

    import mrd_pkg::*;

    // hold frame_length and last_result while stalled
    `MRD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(frame_length) && $stable(last_result), "result beat changed while stalled")
    // in_ready is low in the cycle after taking a byte
    `MRD_ASSERT_NEXT(a_busy_after_beat, in_valid && in_ready, !in_ready, "ready again straight after input beat")
    `MRD_ASSERT_NOW(a_mch_action, out_valid, (action == ACT_LOCAL_MCH) == (function_code == FC_MCH), "multichannel action and code disagree")
    `MRD_ASSERT_NOW(a_read_len, out_valid && function_code == FC_READ, frame_length == 9'd8, "read frame length not eight")
    `MRD_ASSERT_NOW(a_chan_zero, out_valid && function_code != FC_MCH, first_channel == 16'd0 && chan_total == 8'd0, "channel fields set on non-multichannel frame")

endmodule

bind modbus_rtu_request_deframer_top mrd_checker u_mrd_checker (.*);

FILE: tb/sv/modbus_rtu_request_deframer_top_tb.sv
// ----------------------------------------------------------------------------
// Modbus RTU request deframer testbench
// Streams directed and random byte sequences (good, corrupted, oversized and
// hidden frames, noise) through the deframer under random stalls on both
// sides. A local frame decoder predicts every reported frame, and each output
// beat is compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module modbus_rtu_request_deframer_top_tb;
    import mrd_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int LIMIT       = 600000;
    localparam int SETTLE      = 800;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        mrd_res_t res;
        logic     last;
    } frame_rep_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [7:0]            rx_byte = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [1:0]            action;
    logic [7:0]            device_addr;
    logic [7:0]            function_code;
    logic [15:0]           start_addr;
    logic [15:0]           reg_count;
    logic [15:0]           first_channel;
    logic [7:0]            chan_total;
    logic [8:0]            frame_length;
    logic [7:0]            dropped_bytes;
    logic                  last_result;

    modbus_rtu_request_deframer_top dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // decoder state
    logic [7:0]  rx_mem [DEPTH];
    int          head_m;
    int          fill_m;
    int          drops_m;
    bit          fwd_m;
    int          win_lo_m;
    int          win_hi_m;
    frame_rep_t  pending_frames [$];

    int          errors = 0;
    int          cycles = 0;
    bit          no_idle = 0;
    bit          hold_req = 0;
    logic [7:0]  tx_q [$];

    function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic int peek(int off);
        return rx_mem[(head_m + off) % DEPTH];
    endfunction

    function automatic void drop_head();
        head_m = (head_m + 1) % DEPTH;
        fill_m--;
        if (drops_m < 255)
            drops_m++;
    endfunction

    function automatic void decode_byte(logic [7:0] b);
        int         n, fc, len, span;
        logic [15:0] crc;
        frame_rep_t e;
        bit         loc;
        n = 0;
        if (fill_m >= DEPTH)
            drop_head();
        rx_mem[(head_m + fill_m) % DEPTH] = b;
        fill_m++;
        while (n < RESULT_LIMIT && fill_m >= MIN_SCAN)
        begin
            fc = peek(1);
            if (fc == FC_READ)
                len = 8;
            else if (fc == FC_WRITE)
                len = peek(6) + 9;
            else if (fc == FC_MCH)
                len = 8 + 2 * peek(2);
            else
            begin
                drop_head();
                continue;
            end
            if (len > DEPTH)
            begin
                drop_head();
                continue;
            end
            if (fill_m < len)
                break;
            crc = CRC_INIT;
            for (int i = 0; i < len - 2; i++)
                crc = crc_step(crc, 8'(peek(i)));
            if (crc[7:0] != peek(len - 2) || crc[15:8] != peek(len - 1))
            begin
                drop_head();
                continue;
            end
            e = '0;
            e.res.device_addr   = 8'(peek(0));
            e.res.function_code = 8'(fc);
            e.res.frame_length  = 9'(len);
            e.res.dropped_bytes = 8'(drops_m);
            if (fc == FC_MCH)
            begin
                e.res.action        = ACT_LOCAL_MCH;
                e.res.reg_count     = 16'(peek(2));
                e.res.first_channel = {8'(peek(len - 5)), 8'(peek(len - 4))};
                e.res.chan_total    = 8'(peek(len - 3));
            end
            else
            begin
                e.res.start_addr = {8'(peek(2)), 8'(peek(3))};
                e.res.reg_count  = {8'(peek(4)), 8'(peek(5))};
                span = (fc == FC_READ) ? int'(e.res.reg_count) : (peek(6) >> 1);
                loc  = int'(e.res.start_addr) >= win_lo_m
                       && int'(e.res.start_addr) + span < win_hi_m;
                if (fwd_m && !loc)
                    e.res.action = ACT_FORWARD;
                else
                    e.res.action = (fc == FC_READ) ? ACT_LOCAL_READ : ACT_LOCAL_WRITE;
            end
            pending_frames.push_back(e);
            drops_m = 0;
            head_m  = (head_m + len) % DEPTH;
            fill_m -= len;
            n++;
        end
        if (n > 0)
            pending_frames[pending_frames.size() - 1].last = 1'b1;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
        errors++;
    endtask

    // output beats are stable at the falling edge and taken at the next rising edge
    always @(negedge clk)
    begin
        frame_rep_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_frames.size() == 0)
                report("unexpected beat, frame_length", frame_length, 0);
            else
            begin
                e = pending_frames.pop_front();
                if (action != e.res.action)
                    report("action", action, e.res.action);
                if (device_addr != e.res.device_addr)
                    report("device_addr", device_addr, e.res.device_addr);
                if (function_code != e.res.function_code)
                    report("function_code", function_code, e.res.function_code);
                if (start_addr != e.res.start_addr)
                    report("start_addr", start_addr, e.res.start_addr);
                if (reg_count != e.res.reg_count)
                    report("reg_count", reg_count, e.res.reg_count);
                if (first_channel != e.res.first_channel)
                    report("first_channel", first_channel, e.res.first_channel);
                if (chan_total != e.res.chan_total)
                    report("chan_total", chan_total, e.res.chan_total);
                if (frame_length != e.res.frame_length)
                    report("frame_length", frame_length, e.res.frame_length);
                if (dropped_bytes != e.res.dropped_bytes)
                    report("dropped_bytes", dropped_bytes, e.res.dropped_bytes);
                if (last_result != e.last)
                    report("last_result", last_result, e.last);
            end
        end
    end

    // receiver: random stall bursts and one long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 0;
                out_ready <= 1'b1;
            end
            else if (!no_idle && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_byte(logic [7:0] b);
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
        decode_byte(b);
    endtask

    task automatic send_queued();
        logic [7:0] b;
        while (tx_q.size() > 0)
        begin
            b = tx_q.pop_front();
            send_byte(b);
            if (!no_idle && tx_q.size() > 0 && $urandom_range(0, 5) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_frames.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_regs(bit fm, int lo, int hi);
        cfg_write <= 1'b1;
        cfg_index <= CFG_FORWARD_MODE;
        cfg_data  <= CFG_DATA_W'(fm);
        @(posedge clk);
        cfg_index <= CFG_WINDOW_LOW;
        cfg_data  <= CFG_DATA_W'(lo);
        @(posedge clk);
        cfg_index <= CFG_WINDOW_HIGH;
        cfg_data  <= CFG_DATA_W'(hi);
        @(posedge clk);
        cfg_write <= 1'b0;
        fwd_m    = fm;
        win_lo_m = lo & 16'hFFFF;
        win_hi_m = hi & 17'h1FFFF;
    endtask

    // append body plus CRC, low byte first; corrupt flips one CRC bit
    task automatic queue_frame(logic [7:0] body [$], bit corrupt);
        logic [15:0] crc;
        crc = CRC_INIT;
        foreach (body[i])
        begin
            crc = crc_step(crc, body[i]);
            tx_q.push_back(body[i]);
        end
        if (corrupt)
            crc ^= 16'h1 << $urandom_range(0, 15);
        tx_q.push_back(crc[7:0]);
        tx_q.push_back(crc[15:8]);
    endtask

    function automatic logic [15:0] pick_addr();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return win_lo_m + $urandom_range(0, 3) - 1;
            2: return win_hi_m - $urandom_range(0, 20);
            default: return $urandom_range(0, 300);
        endcase
    endfunction

    task automatic queue_request(logic [7:0] fc, int size, bit corrupt);
        logic [7:0]  body [$];
        logic [15:0] sa, cnt;
        sa  = pick_addr();
        cnt = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
        body.push_back($urandom);
        body.push_back(fc);
        if (fc == FC_MCH)
        begin
            body.push_back(size);
            repeat (3 + 2 * size) body.push_back($urandom);
        end
        else
        begin
            body.push_back(sa[15:8]);
            body.push_back(sa[7:0]);
            body.push_back(cnt[15:8]);
            body.push_back(cnt[7:0]);
            if (fc == FC_WRITE)
            begin
                body.push_back(size);
                repeat (size) body.push_back($urandom);
            end
        end
        queue_frame(body, corrupt);
    endtask

    task automatic queue_random();
        logic [7:0] fc;
        int         pick;
        pick = $urandom_range(0, 19);
        fc = (pick % 3 == 0) ? FC_READ : (pick % 3 == 1) ? FC_WRITE : FC_MCH;
        if (pick < 12)
            queue_request(fc, $urandom_range(0, 6), 0);
        else if (pick < 15)
            queue_request(fc, $urandom_range(0, 6), 1);
        else if (pick < 17)
            repeat ($urandom_range(1, 3)) tx_q.push_back($urandom);
        else if (pick < 18)
        begin
            // byte count too large for the buffer
            tx_q.push_back($urandom);
            tx_q.push_back(FC_WRITE);
            repeat (4) tx_q.push_back($urandom);
            tx_q.push_back($urandom_range(248, 255));
        end
        else
        begin
            // long false head hiding several complete frames
            tx_q.push_back($urandom_range(0, 2));
            tx_q.push_back(FC_MCH);
            tx_q.push_back($urandom_range(4, 12));
            repeat ($urandom_range(3, 10)) queue_request(FC_READ, 0, 0);
        end
    endtask

    localparam logic [7:0] DIRECTED [18] = '{
        8'h01, 8'h03, 8'h00, 8'h00, 8'h00, 8'h01, 8'h84, 8'h0A,
        8'hFF, 8'h00, 8'hA5,
        8'h01, 8'h10, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF
    };

    initial
    begin
        int   sent;
        logic [7:0] body [$];
        head_m = 0; fill_m = 0; drops_m = 0;
        fwd_m = 0; win_lo_m = 0; win_hi_m = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            send_byte(DIRECTED[i]);
            if (i == 7)
                pending_frames[$] = '{res: '{ACT_LOCAL_READ, 8'h01, FC_READ, 16'h0000,
                    16'h0001, 16'h0000, 8'h00, 9'd8, 8'd0}, last: 1'b1};
        end
        body = '{8'hFF, FC_WRITE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
        queue_frame(body, 0);
        body = '{8'h00, FC_MCH, 8'h00, 8'hFF, 8'hFF, 8'hFF};
        queue_frame(body, 0);
        send_queued();
        drain();

        // full-buffer multichannel frame with a bad CRC, then drop every byte of it
        tx_q.push_back(8'h01);
        tx_q.push_back(FC_MCH);
        tx_q.push_back(8'd124);
        repeat (253) tx_q.push_back(8'hA5);
        queue_request(FC_READ, 0, 0);
        send_queued();
        drain();

        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0: set_regs(1, 0, 65536);
                1: set_regs(1, 100, 200);
                2: set_regs(1, 65535, 0);
                3: set_regs(0, 65535, 65536);
                4: set_regs(1, 0, 0);
                5: set_regs(1, $urandom_range(0, 300), $urandom_range(0, 400));
                default: set_regs(1, 0, 131071);
            endcase
            no_idle  = (ph == 6);
            hold_req = (ph == 1);
            if (ph == 1)
                repeat (3) queue_request(FC_READ, 0, 0);
            sent = 0;
            while (sent < 14)
            begin
                queue_random();
                sent += tx_q.size();
                send_queued();
            end
            drain();
        end

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/mrd_pkg.sv
sv/mrd_ram.sv
sv/mrd_ctrl.sv
sv/mrd_datapath.sv
sv/modbus_rtu_request_deframer_top.sv
sv/mrd_checker.sv
tb/sv/modbus_rtu_request_deframer_top_tb.sv
